// ===== src/msixicm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msixicm_pkg
// Shared constants, codes and field types for the MSI-X cause/mask unit.
// ----------------------------------------------------------------------------
package msixicm_pkg;

  localparam int NUM_QUEUES  = 16;
  localparam int NUM_VECTORS = 32;

  // Vectors that exist; bits above NUM_VECTORS are dropped
  localparam logic [31:0] VEC_MASK = 32'hFFFF_FFFF >> (32 - NUM_VECTORS);
  localparam logic [4:0]  QUEUE_LIMIT = 5'(NUM_QUEUES);

  // Field types
  typedef logic [2:0]  kind_t;
  typedef logic [3:0]  queue_t;
  typedef logic [2:0]  vf_t;
  typedef logic [2:0]  reg_sel_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  cfg_index_t;
  typedef logic [63:0] cfg_data_t;

  // Event kinds
  localparam kind_t KIND_TX_DONE = 3'd0;
  localparam kind_t KIND_RX_DONE = 3'd1;
  localparam kind_t KIND_OTHER   = 3'd2;
  localparam kind_t KIND_MAILBOX = 3'd3;
  localparam kind_t KIND_WRITE   = 3'd4;
  localparam kind_t KIND_READ    = 3'd5;
  localparam kind_t KIND_TICK    = 3'd6;

  // Write selects
  localparam reg_sel_t WR_EICR = 3'd0;
  localparam reg_sel_t WR_IMC  = 3'd1;
  localparam reg_sel_t WR_IMS  = 3'd2;
  localparam reg_sel_t WR_EIMC = 3'd3;
  localparam reg_sel_t WR_EIMS = 3'd4;
  localparam reg_sel_t WR_EICS = 3'd5;
  localparam reg_sel_t WR_ICS  = 3'd6;

  // Read selects
  localparam reg_sel_t RD_ICR  = 3'd0;
  localparam reg_sel_t RD_EICR = 3'd1;

  // Configuration register indexes
  localparam cfg_index_t CFG_IVAR_PAIR_0 = 3'd0;
  localparam cfg_index_t CFG_IVAR_PAIR_1 = 3'd1;
  localparam cfg_index_t CFG_IVAR_PAIR_2 = 3'd2;
  localparam cfg_index_t CFG_IVAR_PAIR_3 = 3'd3;
  localparam cfg_index_t CFG_MISC_BYTE   = 3'd4;
  localparam cfg_index_t CFG_FLAGS       = 3'd5;
  localparam cfg_index_t CFG_MBX_MASK    = 3'd6;
  localparam cfg_index_t CFG_AUTO_MASK   = 3'd7;

  // Legacy cause bits
  localparam word_t ICR_TXDW = 32'h0000_0001;
  localparam word_t ICR_RXDW = 32'h0000_0080;
  localparam word_t ICR_VMMB = 32'h0000_0100;

  // general_flags bit positions and allocation byte fields
  localparam int FLAG_MSIX      = 0;
  localparam int FLAG_AUTO_MASK = 1;
  localparam int FLAG_NSICR     = 2;
  localparam int ALLOC_VALID    = 7;

endpackage : msixicm_pkg

`default_nettype wire

// ===== src/msixicm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msixicm_item_if / msixicm_result_if
// Valid/ready channels for event transactions and result transactions.
// ----------------------------------------------------------------------------
interface msixicm_item_if;
  import msixicm_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    kind;
  queue_t   queue_number;
  vf_t      vf_number;
  word_t    cause_bits;
  reg_sel_t reg_select;
  word_t    write_data;

  modport source (
    output valid, kind, queue_number, vf_number, cause_bits, reg_select, write_data,
    input  ready
  );
  modport sink (
    input  valid, kind, queue_number, vf_number, cause_bits, reg_select, write_data,
    output ready
  );
endinterface : msixicm_item_if

interface msixicm_result_if;
  import msixicm_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_data;
  word_t notify_mask;
  logic  throttle_active;

  modport source (
    output valid, read_data, notify_mask, throttle_active,
    input  ready
  );
  modport sink (
    input  valid, read_data, notify_mask, throttle_active,
    output ready
  );
endinterface : msixicm_result_if

`default_nettype wire

// ===== src/msix_interrupt_cause_mask_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msix_interrupt_cause_mask_unit
// MSI-X cause/mask controller with IVAR mapping, moderation and auto-mask.
// ----------------------------------------------------------------------------
// Takes one event transaction per clock (queue done, other cause, mailbox,
// register write, register read or moderation tick) and returns exactly one
// result transaction for it, in the cycle after acceptance, from an output
// register. All cause/mask state is updated in the accepting cycle by a
// single pass of mask logic and a lowest-set-bit pick, so back-to-back
// transactions see each other's effects with no bubbles: the sustained rate
// is one transaction per cycle, and the only stall is a held result that the
// sink has not taken (the input is ready whenever the output register is empty
// or being drained in the same cycle). The user must write the configuration
// registers via the plain cfg port while no transaction is in flight (unchecked).
// ----------------------------------------------------------------------------
module msix_interrupt_cause_mask_unit (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_write_en,
  input  msixicm_pkg::cfg_index_t cfg_index,
  input  msixicm_pkg::cfg_data_t  cfg_write_data,
  msixicm_item_if.sink            in_item,
  msixicm_result_if.source        out_result
);
  import msixicm_pkg::*;

  // Configuration registers
  logic [63:0] ivar_pair [4];
  logic [7:0]  misc_vector_byte;
  logic [2:0]  general_flags;
  logic [7:0]  mailbox_vf_mask;
  word_t       auto_mask_bits;

  // Architectural state
  word_t legacy_cause, legacy_cause_next;
  word_t legacy_mask, legacy_mask_next;
  word_t legacy_cause_set, legacy_cause_set_next;
  word_t extended_cause, extended_cause_next;
  word_t extended_mask, extended_mask_next;
  word_t pending_vectors, pending_vectors_next;
  logic  throttling, throttling_next;

  // Output register
  logic  res_valid;
  word_t res_read_data;
  word_t res_notify;
  logic  res_throttle;

  // Per-transaction working values
  logic       accept;
  logic [4:0] queue_cause;
  logic [7:0] queue_byte;
  logic [7:0] ivar_bytes [32];
  word_t      raise_set;
  word_t      raise_en;
  word_t      raise_low;
  word_t      notify;
  word_t      read_value;
  word_t      other_icr;
  logic       other_go;

  // Ready whenever the output register is free or draining this cycle
  assign in_item.ready = !res_valid || out_result.ready;
  assign accept        = in_item.valid && in_item.ready;

  assign out_result.valid           = res_valid;
  assign out_result.read_data       = res_read_data;
  assign out_result.notify_mask     = res_notify;
  assign out_result.throttle_active = res_throttle;

  // Flatten the IVAR pairs into one allocation byte per queue cause
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int b = 0; b < 8; b++) begin
        ivar_bytes[p * 8 + b] = ivar_pair[p][b * 8 +: 8];
      end
    end
  end

  // rx queue q -> 4q or 4(q-8)+2, tx adds one; outside msix mode cause 0
  assign queue_cause = general_flags[FLAG_MSIX]
                     ? {in_item.queue_number[2:0], in_item.queue_number[3],
                        (in_item.kind == KIND_TX_DONE)}
                     : 5'd0;
  assign queue_byte  = ivar_bytes[queue_cause];

  always_comb begin
    legacy_cause_next     = legacy_cause;
    legacy_mask_next      = legacy_mask;
    legacy_cause_set_next = legacy_cause_set;
    extended_cause_next   = extended_cause;
    extended_mask_next    = extended_mask;
    pending_vectors_next  = pending_vectors;
    throttling_next       = throttling;
    raise_set             = '0;
    raise_en              = '0;
    raise_low             = '0;
    notify                = '0;
    read_value            = '0;
    other_icr             = '0;
    other_go              = 1'b0;

    // Decode the transaction into state edits and a set of vectors to raise
    unique case (in_item.kind)
      KIND_TX_DONE, KIND_RX_DONE: begin
        if ({1'b0, in_item.queue_number} < QUEUE_LIMIT) begin
          legacy_cause_next = legacy_cause
                            | ((in_item.kind == KIND_TX_DONE) ? ICR_TXDW : ICR_RXDW);
          if (queue_byte[ALLOC_VALID]) begin
            raise_set = word_t'(1) << queue_byte[4:0];
          end
        end
      end
      KIND_OTHER: begin
        other_icr = in_item.cause_bits;
        other_go  = 1'b1;
      end
      KIND_MAILBOX: begin
        if (mailbox_vf_mask[in_item.vf_number]) begin
          other_icr = ICR_VMMB;
          other_go  = 1'b1;
        end
      end
      KIND_WRITE: begin
        unique case (in_item.reg_select)
          WR_EICR: extended_cause_next = extended_cause & ~in_item.write_data;
          WR_IMC:  legacy_mask_next = legacy_mask & ~in_item.write_data;
          WR_IMS:  legacy_mask_next = legacy_mask | in_item.write_data;
          WR_EIMC: extended_mask_next = extended_mask & ~in_item.write_data;
          WR_EIMS: begin
            // Unmasking a vector with its cause already set raises it now
            raise_set = in_item.write_data & VEC_MASK & ~extended_mask & extended_cause;
            extended_mask_next = extended_mask | (in_item.write_data & VEC_MASK);
          end
          WR_EICS: raise_set = in_item.write_data;
          WR_ICS: begin
            legacy_cause_set_next = in_item.write_data;
            other_icr = in_item.write_data;
            other_go  = 1'b1;
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        if (in_item.reg_select == RD_ICR) begin
          read_value = legacy_cause;
          if (general_flags[FLAG_NSICR] || ((legacy_cause & legacy_cause_set) != '0)
              || (legacy_mask == '0)) begin
            legacy_cause_next = '0;
          end
        end else if (in_item.reg_select == RD_EICR) begin
          read_value          = extended_cause;
          extended_cause_next = '0;
        end
      end
      KIND_TICK: begin
        // Flush pending at a tick; an empty tick closes the window
        if (throttling) begin
          if (pending_vectors != '0) begin
            notify               = pending_vectors;
            pending_vectors_next = '0;
          end else begin
            throttling_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Other cause: latch into ICR, route through the misc byte if unmasked
    if (other_go) begin
      legacy_cause_next = legacy_cause | other_icr;
      if (((legacy_mask & other_icr) != '0) && misc_vector_byte[ALLOC_VALID]) begin
        raise_set = word_t'(1) << misc_vector_byte[4:0];
      end
    end

    // Raise: set cause bits, notify lowest enabled or hold as pending
    raise_set           = raise_set & VEC_MASK;
    extended_cause_next = extended_cause_next | raise_set;
    raise_en            = raise_set & extended_mask_next;
    raise_low           = raise_en & (~raise_en + word_t'(1));
    if (raise_en != '0) begin
      if (!throttling_next) begin
        notify               = pending_vectors_next | raise_low;
        pending_vectors_next = raise_en & ~raise_low;
        throttling_next      = 1'b1;
      end else begin
        pending_vectors_next = pending_vectors_next | raise_en;
      end
      if (general_flags[FLAG_AUTO_MASK]) begin
        extended_mask_next = extended_mask_next & ~(raise_en & auto_mask_bits);
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 4; p++) begin
        ivar_pair[p] <= '0;
      end
      misc_vector_byte <= '0;
      general_flags    <= '0;
      mailbox_vf_mask  <= '0;
      auto_mask_bits   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_IVAR_PAIR_0: ivar_pair[0] <= cfg_write_data;
        CFG_IVAR_PAIR_1: ivar_pair[1] <= cfg_write_data;
        CFG_IVAR_PAIR_2: ivar_pair[2] <= cfg_write_data;
        CFG_IVAR_PAIR_3: ivar_pair[3] <= cfg_write_data;
        CFG_MISC_BYTE:   misc_vector_byte <= cfg_write_data[7:0];
        CFG_FLAGS:       general_flags <= cfg_write_data[2:0];
        CFG_MBX_MASK:    mailbox_vf_mask <= cfg_write_data[7:0];
        CFG_AUTO_MASK:   auto_mask_bits <= cfg_write_data[31:0];
        default: ;
      endcase
    end
  end

  // State advances only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_cause     <= '0;
      legacy_mask      <= '0;
      legacy_cause_set <= '0;
      extended_cause   <= '0;
      extended_mask    <= '0;
      pending_vectors  <= '0;
      throttling       <= 1'b0;
    end else if (accept) begin
      legacy_cause     <= legacy_cause_next;
      legacy_mask      <= legacy_mask_next;
      legacy_cause_set <= legacy_cause_set_next;
      extended_cause   <= extended_cause_next;
      extended_mask    <= extended_mask_next;
      pending_vectors  <= pending_vectors_next;
      throttling       <= throttling_next;
    end
  end

  // Result register: load on accept, drop when taken, hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_read_data <= read_value;
      res_notify    <= notify;
      res_throttle  <= throttling_next;
    end
  end

`ifndef ASSERT_OFF
  // Nothing may be pending while the moderation window is closed
  a_pending_needs_window: assert property (@(posedge clk) disable iff (rst)
    !throttling |-> (pending_vectors == '0))
    else $error("pending vectors with moderation window closed");

  // A notification always leaves the window open
  a_notify_opens_window: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_notify != '0)) |-> res_throttle)
    else $error("notification reported with window closed");

  // Only existing vectors may appear in cause or pending state
  a_vectors_in_range: assert property (@(posedge clk) disable iff (rst)
    ((extended_cause | pending_vectors) & ~VEC_MASK) == '0)
    else $error("vector beyond NUM_VECTORS in state");

  // A stalled result is never overwritten by a new transaction
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_result.ready) |-> !accept)
    else $error("transaction accepted over a held result");

  // A notified vector set has at most one new vector when the window opens
  a_single_on_open: assert property (@(posedge clk) disable iff (rst)
    (accept && !throttling && (in_item.kind != KIND_TICK)) |=> $onehot0(res_notify))
    else $error("more than one vector notified on window open");
`endif

endmodule : msix_interrupt_cause_mask_unit

`default_nettype wire
